>>> sv/drilling_canned_cycle_expander_assert.svh
// Assertion macros for the drilling canned-cycle expander
`ifndef DRILLING_CANNED_CYCLE_EXPANDER_ASSERT_SVH
`define DRILLING_CANNED_CYCLE_EXPANDER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DCCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define DCCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dcce_pkg.sv
package dcce_pkg;

    localparam int MAX_PECKS = 28;
    localparam int IW        = $clog2(MAX_PECKS + 2);
    localparam int AW        = 28;

    localparam logic [2:0] MODE_END      = 3'd0;
    localparam logic [2:0] MODE_START_IZ = 3'd1;
    localparam logic [2:0] MODE_START_R  = 3'd2;
    localparam logic [2:0] MODE_HOLE     = 3'd3;

    localparam logic [2:0] KIND_RAPID  = 3'd0;
    localparam logic [2:0] KIND_FEED   = 3'd1;
    localparam logic [2:0] KIND_DWELLS = 3'd2;
    localparam logic [2:0] KIND_DWELLM = 3'd3;
    localparam logic [2:0] KIND_NH     = 3'd4;

    localparam logic [2:0] AX_Z = 3'd4;

    localparam logic CFG_DWELL_MS = 1'b0;
    localparam logic CFG_DECIMAL  = 1'b1;

    typedef struct packed {
        logic [2:0]         mode;
        logic [6:0]         arg_present;
        logic signed [23:0] x_word;
        logic signed [23:0] y_word;
        logic signed [23:0] z_word;
        logic signed [23:0] r_word;
        logic [23:0]        f_word;
        logic [22:0]        q_word;
        logic [23:0]        p_word;
        logic signed [23:0] work_z;
        logic               absolute_coords;
    } t_in;

    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         axis_mask;
        logic signed [23:0] x_target;
        logic signed [23:0] y_target;
        logic signed [23:0] z_target;
        logic [23:0]        feed_rate;
        logic [33:0]        dwell_amount;
        logic               last;
        logic               peck_clamped;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_XY, S_RPLANE, S_PFEED, S_PRAPID,
        S_FINAL, S_DWELL, S_RETRACT, S_END, S_NH
    } t_state;

    typedef enum logic [2:0] {
        SEL_XY, SEL_RPLANE, SEL_PFEED, SEL_FINAL, SEL_DWELL, SEL_RETRACT, SEL_END, SEL_NH
    } t_sel;

    typedef struct packed {
        logic start;
        logic fin;
        logic hole;
        logic prep;
        logic step;
        logic emit;
        logic last;
        t_sel sel;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic ret_to_rpl;
        logic xy_nz;
        logic peck_zero;
        logic depth_pos;
        logic more;
        logic dwell_nz;
        logic out_free;
    } t_status;

endpackage

>>> sv/dcce_ctrl.sv
`include "drilling_canned_cycle_expander_assert.svh"

module dcce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [2:0]       i_mode,
    input  logic             i_abs,
    input  dcce_pkg::t_status i_st,
    output logic             o_stall,
    output dcce_pkg::t_cmd   o_cmd
);
    import dcce_pkg::*;

    t_state r_state, n_state;
    logic   acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.sel = SEL_NH;
        o_stall = (r_state != S_IDLE);
        acc     = i_valid && (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (i_mode == MODE_START_IZ || i_mode == MODE_START_R) begin
                        o_cmd.start = 1'b1;
                    end else if (i_mode == MODE_END) begin
                        o_cmd.fin = 1'b1;
                        if (i_st.ret_to_rpl) n_state = S_END;
                    end else if (i_mode == MODE_HOLE && i_st.active && i_abs) begin
                        o_cmd.hole = 1'b1;
                        n_state    = S_PREP;
                    end else begin
                        n_state = S_NH;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_XY;
            end
            S_XY: begin
                o_cmd.sel = SEL_XY;
                if (!i_st.xy_nz) begin
                    n_state = S_RPLANE;
                end else if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_RPLANE;
                end
            end
            S_RPLANE: begin
                o_cmd.sel = SEL_RPLANE;
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_st.peck_zero)     n_state = S_FINAL;
                    else if (i_st.more)     n_state = S_PFEED;
                    else if (i_st.depth_pos) n_state = S_FINAL;
                    else if (i_st.dwell_nz) n_state = S_DWELL;
                    else                    n_state = S_RETRACT;
                end
            end
            S_PFEED: begin
                o_cmd.sel = SEL_PFEED;
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_PRAPID;
                end
            end
            S_PRAPID: begin
                o_cmd.sel = SEL_RPLANE;
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.step = 1'b1;
                    n_state    = S_FINAL;
                end
            end
            S_FINAL: begin
                // more is re-checked here after each peck step
                o_cmd.sel = SEL_FINAL;
                if (!i_st.peck_zero && i_st.more) begin
                    n_state = S_PFEED;
                end else if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_st.dwell_nz ? S_DWELL : S_RETRACT;
                end
            end
            S_DWELL: begin
                o_cmd.sel = SEL_DWELL;
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_RETRACT;
                end
            end
            S_RETRACT: begin
                o_cmd.sel = SEL_RETRACT;
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_END: begin
                o_cmd.sel = SEL_END;
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_NH: begin
                o_cmd.sel = SEL_NH;
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `DCCE_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, i_st.out_free, "emit into full slot")
    `DCCE_ASSERT_NXT(a_hole_prep, i_clk, i_rst_n, o_cmd.hole, r_state == S_PREP, "hole not prepared")
    `DCCE_ASSERT_IMP(a_idle_quiet, i_clk, i_rst_n, r_state == S_IDLE, !o_cmd.emit, "emit while idle")

endmodule

>>> sv/dcce_dp.sv
module dcce_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcce_pkg::t_in     i_in,
    input  dcce_pkg::t_cmd    i_cmd,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic              i_cfg_data,
    input  logic              i_stall,
    output dcce_pkg::t_status o_st,
    output logic              o_valid,
    output dcce_pkg::t_out    o_out
);
    import dcce_pkg::*;

    logic               r_ms, r_dec, r_active, r_rtr;
    logic signed [23:0] r_init, r_ret, r_dep, r_rpl, r_x, r_y;
    logic [23:0]        r_feed, r_dwell;
    logic [22:0]        r_peck;
    logic [1:0]         r_xy;
    logic signed [24:0] r_depth;
    logic [AW-1:0]      r_prod, r_acc;
    logic [IW-1:0]      r_i;
    logic [33:0]        r_damt;
    logic               r_ovalid;
    t_out               r_out, n_out;
    logic               clamped, dpos;
    logic signed [23:0] rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms <= 1'b0; r_dec <= 1'b0; r_active <= 1'b0; r_rtr <= 1'b0;
            r_init <= '0; r_ret <= '0; r_dep <= '0; r_rpl <= '0;
            r_feed <= '0; r_peck <= '0; r_dwell <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_DWELL_MS) r_ms  <= i_cfg_data;
                if (i_cfg_idx == CFG_DECIMAL)  r_dec <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_init   <= i_in.work_z;
                r_rtr    <= (i_in.mode == MODE_START_R);
                r_dep    <= '0; r_rpl <= '0; r_feed <= '0; r_peck <= '0; r_dwell <= '0;
                r_active <= 1'b1;
            end
            if (i_cmd.fin) r_active <= 1'b0;
            if (i_cmd.hole) begin
                if (i_in.arg_present[2]) r_dep   <= i_in.z_word;
                if (i_in.arg_present[3]) r_rpl   <= i_in.r_word;
                if (i_in.arg_present[4]) r_feed  <= i_in.f_word;
                if (i_in.arg_present[5]) r_peck  <= i_in.q_word;
                if (i_in.arg_present[6]) r_dwell <= i_in.p_word;
                r_ret <= r_rtr ? rr : r_init;
            end
        end
    end

    assign rr = i_in.arg_present[3] ? i_in.r_word : r_rpl;

    always_ff @(posedge i_clk) begin
        if (i_cmd.hole) begin
            r_x  <= i_in.x_word;
            r_y  <= i_in.y_word;
            r_xy <= i_in.arg_present[1:0];
        end
        if (i_cmd.prep) begin
            r_depth <= 25'(r_rpl) - 25'(r_dep);
            r_prod  <= AW'(r_peck) * AW'(MAX_PECKS + 1);
            r_acc   <= AW'(r_peck);
            r_i     <= IW'(1);
            r_damt  <= (r_ms && r_dec) ? 34'(r_dwell) * 34'd1000 : 34'(r_dwell);
        end else if (i_cmd.step) begin
            r_acc <= r_acc + AW'(r_peck);
            r_i   <= r_i + IW'(1);
        end
    end

    assign dpos    = !r_depth[24] && (r_depth != '0);
    assign clamped = dpos && (r_peck != '0) && (AW'(r_depth[23:0]) > r_prod);

    always_comb begin
        o_st.active       = r_active;
        o_st.ret_to_rpl   = r_rtr;
        o_st.xy_nz        = (r_xy != 2'b00);
        o_st.peck_zero    = (r_peck == '0);
        o_st.depth_pos    = dpos;
        o_st.more         = dpos && (r_acc < AW'(r_depth[23:0])) && (r_i <= IW'(MAX_PECKS));
        o_st.dwell_nz     = (r_dwell != '0);
        o_st.out_free     = !r_ovalid || !i_stall;
    end

    always_comb begin
        n_out              = '0;
        n_out.last         = i_cmd.last;
        n_out.peck_clamped = clamped;
        case (i_cmd.sel)
            SEL_XY: begin
                n_out.kind      = KIND_RAPID;
                n_out.axis_mask = {1'b0, r_xy};
                n_out.x_target  = r_xy[0] ? r_x : '0;
                n_out.y_target  = r_xy[1] ? r_y : '0;
            end
            SEL_RPLANE: begin
                n_out.kind      = KIND_RAPID;
                n_out.axis_mask = AX_Z;
                n_out.z_target  = r_rpl;
            end
            SEL_PFEED: begin
                n_out.kind      = KIND_FEED;
                n_out.axis_mask = AX_Z;
                n_out.z_target  = r_rpl - $signed(r_acc[23:0]);
                n_out.feed_rate = r_feed;
            end
            SEL_FINAL: begin
                n_out.kind      = KIND_FEED;
                n_out.axis_mask = AX_Z;
                n_out.z_target  = r_dep;
                n_out.feed_rate = r_feed;
            end
            SEL_DWELL: begin
                n_out.kind         = r_ms ? KIND_DWELLM : KIND_DWELLS;
                n_out.dwell_amount = r_damt;
            end
            SEL_RETRACT: begin
                n_out.kind      = KIND_RAPID;
                n_out.axis_mask = AX_Z;
                n_out.z_target  = r_ret;
            end
            SEL_END: begin
                n_out.kind         = KIND_RAPID;
                n_out.axis_mask    = AX_Z;
                n_out.z_target     = r_init;
                n_out.peck_clamped = 1'b0;
            end
            default: begin
                n_out.kind         = KIND_NH;
                n_out.peck_clamped = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)            r_ovalid <= 1'b0;
        else if (i_cmd.emit)     r_ovalid <= 1'b1;
        else if (!i_stall)       r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

endmodule

>>> sv/drilling_canned_cycle_expander.sv
// Drilling canned-cycle expander.
// Input channel i_valid/o_stall carries one command request (t_in); a request
// is taken when i_valid is high and o_stall low. Output channel o_valid/i_stall
// carries motion/dwell results (t_out), taken when o_valid is high and i_stall
// low; the final result of a request has last set.
// Start requests give no result and leave the sequencer idle. End requests
// after an R-plane start, and not-handled requests, load their result from
// S_END or S_NH into a single output register once free; the next request is
// taken the cycle after that. A hole passes through the set-up state S_PREP
// and the X/Y rapid state S_XY (entered even when neither word is given),
// then emits its results, re-checking the peck count in S_FINAL between pecks:
// up to 2 + 2*MAX_PECKS + 3 results; the next request is taken only after
// the last one is loaded. When the receiver stalls, the output register
// holds its result and the sequencer waits. Reset (synchronous, active low)
// clears the cycle state, held words and configuration; the output is empty
// afterwards. Configuration (i_cfg_we, i_cfg_idx, i_cfg_data) is to be
// written by the user only while idle; the block does not enforce this.
module drilling_canned_cycle_expander (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  dcce_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output dcce_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic           i_cfg_data
);
    import dcce_pkg::*;

    t_cmd    cmd;
    t_status st;

    dcce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_in.mode),
        .i_abs   (i_in.absolute_coords),
        .i_st    (st),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    dcce_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_stall    (i_stall),
        .o_st       (st),
        .o_valid    (o_valid),
        .o_out      (o_out)
    );

endmodule
